// ===== rtl/fsns_pkg.sv =====
package fsns_pkg;

  // Widest destination the scanner supports.
  localparam int unsigned MAX_WIDTH = 64;
  localparam int unsigned PLANE_W   = 64;
  localparam int unsigned CFG_DW    = 7;
  localparam int unsigned CFG_AW    = 2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DST_BITS   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FOUR_STATE = 2'd2;

  // Radix codes.
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  // Scan phases; the fourth code behaves as whitespace skipping.
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // Character kinds within the current radix.
  localparam logic [2:0] KIND_DIGIT = 3'd0;
  localparam logic [2:0] KIND_X     = 3'd1;
  localparam logic [2:0] KIND_Z     = 3'd2;
  localparam logic [2:0] KIND_SEP   = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  // Reset values of the registers.
  localparam logic [1:0]        RADIX_RST      = RADIX_DEC;
  localparam logic [CFG_DW-1:0] DST_BITS_RST   = 7'd32;
  localparam logic              FOUR_STATE_RST = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [PLANE_W-1:0] value_plane;
    logic [PLANE_W-1:0] unknown_plane;
    logic               match_ok;
    logic               ender_consumed;
    logic               sign_returned;
    logic               hit_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        radix_mode;
    logic [CFG_DW-1:0] dst_bits;
    logic              four_state_dest;
  } cfg_t;

  typedef struct packed {
    logic       is_space;
    logic       is_dec;
    logic [3:0] dec_val;
    logic       is_x_char;
    logic       is_z_char;
    logic       is_sign;
    logic       is_minus;
    logic [2:0] kind;
    logic [3:0] digit;
  } cls_t;

endpackage

// ===== rtl/fsns_classify.sv =====
module fsns_classify (
  input  logic [7:0]     ch,
  input  logic [1:0]     radix_mode,
  output fsns_pkg::cls_t cls
);

  logic is_dec;
  logic is_lhex;
  logic is_uhex;

  always_comb begin
    is_dec  = (ch >= 8'h30) && (ch <= 8'h39);
    is_lhex = (ch >= 8'h61) && (ch <= 8'h66);
    is_uhex = (ch >= 8'h41) && (ch <= 8'h46);

    // Character tests that do not depend on the radix.
    cls.is_space  = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0d));
    cls.is_dec    = is_dec;
    cls.dec_val   = ch[3:0];
    cls.is_x_char = (ch == 8'h78) || (ch == 8'h58);
    cls.is_z_char = (ch == 8'h7a) || (ch == 8'h5a) || (ch == 8'h3f);
    cls.is_sign   = (ch == 8'h2b) || (ch == 8'h2d);
    cls.is_minus  = (ch == 8'h2d);

    // Kind of the character in the selected radix.
    cls.kind  = fsns_pkg::KIND_NONE;
    cls.digit = ch[3:0];
    if (ch == 8'h5f) begin
      cls.kind = fsns_pkg::KIND_SEP;
    end else if (radix_mode == fsns_pkg::RADIX_DEC) begin
      if (is_dec) cls.kind = fsns_pkg::KIND_DIGIT;
    end else if (cls.is_x_char) begin
      cls.kind = fsns_pkg::KIND_X;
    end else if (cls.is_z_char) begin
      cls.kind = fsns_pkg::KIND_Z;
    end else begin
      case (radix_mode)
        fsns_pkg::RADIX_HEX: begin
          if (is_dec) begin
            cls.kind = fsns_pkg::KIND_DIGIT;
          end else if (is_lhex || is_uhex) begin
            cls.kind  = fsns_pkg::KIND_DIGIT;
            cls.digit = ch[3:0] + 4'd9;
          end
        end
        fsns_pkg::RADIX_OCT: begin
          if ((ch >= 8'h30) && (ch <= 8'h37)) cls.kind = fsns_pkg::KIND_DIGIT;
        end
        default: begin
          if ((ch == 8'h30) || (ch == 8'h31)) cls.kind = fsns_pkg::KIND_DIGIT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/fsns_step.sv =====
module fsns_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  fsns_pkg::in_item_t  item,
  input  fsns_pkg::cfg_t      cfg,
  output logic                emit,
  output fsns_pkg::out_item_t result
);

  localparam int unsigned PW = fsns_pkg::PLANE_W;

  fsns_pkg::cls_t cls;

  logic [1:0]    phase_r, phase_nxt;
  logic          neg_r, neg_nxt;
  logic          dseen_r, dseen_nxt;
  logic [PW-1:0] val_r, val_nxt;
  logic [PW-1:0] unk_r, unk_nxt;

  logic          raw_ok, raw_ender, raw_sgn, raw_end;
  logic [PW-1:0] raw_v, raw_u;
  logic [PW-1:0] dec_v, sh_v, sh_u;
  logic [3:0]    dig_v, dig_u;
  logic [PW-1:0] fin_v, fin_u;
  logic [PW-1:0] mask, ok_v, ok_u;

  fsns_classify u_classify (
    .ch         (item.char_code),
    .radix_mode (cfg.radix_mode),
    .cls        (cls)
  );

  // Decimal accumulate: times ten plus the digit, wrapping at the plane width.
  assign dec_v = (val_r << 3) + (val_r << 1) + PW'(cls.digit);

  // Digit bits for the shifting radices: x is unknown one, z unknown zero.
  always_comb begin
    dig_v = cls.digit;
    dig_u = 4'h0;
    if (cls.kind == fsns_pkg::KIND_X) begin
      dig_v = 4'hf;
      dig_u = 4'hf;
    end else if (cls.kind == fsns_pkg::KIND_Z) begin
      dig_v = 4'h0;
      dig_u = 4'hf;
    end
    case (cfg.radix_mode)
      fsns_pkg::RADIX_HEX: begin
        sh_v = {val_r[PW-5:0], dig_v};
        sh_u = {unk_r[PW-5:0], dig_u};
      end
      fsns_pkg::RADIX_OCT: begin
        sh_v = {val_r[PW-4:0], dig_v[2:0]};
        sh_u = {unk_r[PW-4:0], dig_u[2:0]};
      end
      default: begin
        sh_v = {val_r[PW-2:0], dig_v[0]};
        sh_u = {unk_r[PW-2:0], dig_u[0]};
      end
    endcase
  end

  // Value of a field that ends normally.
  always_comb begin
    if (cfg.radix_mode == fsns_pkg::RADIX_DEC) begin
      fin_v = neg_r ? (PW'(0) - val_r) : val_r;
      fin_u = '0;
    end else begin
      fin_v = val_r;
      fin_u = unk_r;
    end
  end

  // Phase logic for one character.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    dseen_nxt = dseen_r;
    val_nxt   = val_r;
    unk_nxt   = unk_r;
    emit      = 1'b0;
    raw_ok    = 1'b0;
    raw_v     = '0;
    raw_u     = '0;
    raw_ender = 1'b0;
    raw_sgn   = 1'b0;
    raw_end   = 1'b0;
    case (phase_r)
      fsns_pkg::PH_SIGN: begin
        if (!item.end_of_input && cls.is_dec) begin
          val_nxt   = PW'(cls.dec_val);
          dseen_nxt = 1'b1;
          phase_nxt = fsns_pkg::PH_DIGITS;
        end else begin
          emit    = 1'b1;
          raw_sgn = 1'b1;
          raw_end = item.end_of_input;
        end
      end
      fsns_pkg::PH_DIGITS: begin
        if (item.end_of_input || (cls.kind == fsns_pkg::KIND_NONE)) begin
          emit    = 1'b1;
          raw_ok  = dseen_r;
          raw_v   = fin_v;
          raw_u   = fin_u;
          raw_end = item.end_of_input;
        end else if (cls.kind != fsns_pkg::KIND_SEP) begin
          dseen_nxt = 1'b1;
          if (cfg.radix_mode == fsns_pkg::RADIX_DEC) begin
            val_nxt = dec_v;
          end else begin
            val_nxt = sh_v;
            unk_nxt = sh_u;
          end
        end
      end
      default: begin
        phase_nxt = fsns_pkg::PH_SKIP;
        if (item.end_of_input) begin
          emit    = 1'b1;
          raw_end = 1'b1;
        end else if (cls.is_space) begin
          phase_nxt = fsns_pkg::PH_SKIP;
        end else if (cfg.radix_mode == fsns_pkg::RADIX_DEC) begin
          if (cls.is_x_char || cls.is_z_char) begin
            // A lone x or z stands for the whole value.
            emit      = 1'b1;
            raw_ok    = 1'b1;
            raw_v     = cls.is_x_char ? '1 : '0;
            raw_u     = '1;
            raw_ender = 1'b1;
          end else if (cls.is_sign) begin
            neg_nxt   = cls.is_minus;
            phase_nxt = fsns_pkg::PH_SIGN;
          end else if (cls.is_dec) begin
            val_nxt   = PW'(cls.dec_val);
            dseen_nxt = 1'b1;
            phase_nxt = fsns_pkg::PH_DIGITS;
          end else begin
            emit = 1'b1;
          end
        end else if (cls.kind == fsns_pkg::KIND_NONE) begin
          emit = 1'b1;
        end else begin
          phase_nxt = fsns_pkg::PH_DIGITS;
          if (cls.kind != fsns_pkg::KIND_SEP) begin
            dseen_nxt = 1'b1;
            val_nxt   = sh_v;
            unk_nxt   = sh_u;
          end
        end
      end
    endcase
    // Every result returns the field state to its reset values.
    if (emit) begin
      phase_nxt = fsns_pkg::PH_SKIP;
      neg_nxt   = 1'b0;
      dseen_nxt = 1'b0;
      val_nxt   = '0;
      unk_nxt   = '0;
    end
  end

  // Destination width mask, saturated at the widest destination.
  always_comb begin
    if (cfg.dst_bits >= fsns_pkg::CFG_DW'(fsns_pkg::MAX_WIDTH)) begin
      mask = (fsns_pkg::MAX_WIDTH >= PW) ? '1 :
             ((PW'(1) << fsns_pkg::MAX_WIDTH) - PW'(1));
    end else begin
      mask = (PW'(1) << cfg.dst_bits[5:0]) - PW'(1);
    end
  end

  // Result formatting: mismatch clears planes, two-state clears unknowns.
  always_comb begin
    ok_v = raw_ok ? raw_v : '0;
    ok_u = raw_ok ? raw_u : '0;
    if (!cfg.four_state_dest) begin
      ok_v = ok_v & ~ok_u;
      ok_u = '0;
    end
    result.value_plane    = ok_v & mask;
    result.unknown_plane  = ok_u & mask;
    result.match_ok       = raw_ok;
    result.ender_consumed = raw_ender;
    result.sign_returned  = raw_sgn;
    result.hit_end        = raw_end;
  end

  // Field state; it moves only when the held item advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fsns_pkg::PH_SKIP;
      neg_r   <= 1'b0;
      dseen_r <= 1'b0;
      val_r   <= '0;
      unk_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      dseen_r <= dseen_nxt;
      val_r   <= val_nxt;
      unk_r   <= unk_nxt;
    end
  end

endmodule

// ===== rtl/four_state_numeric_field_scanner.sv =====
// Timing: an accepted item is held in the input register, and its result, if any,
// is written into the result register when the item advances.
// Throughput: one item per cycle, set by the single input register to result
// register step; a stalled result holds the next item in the input register.
// Reset: synchronous, active low; clears both channels, the field state and
// the configuration registers to decimal, 32-bit, four-state.
module four_state_numeric_field_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fsns_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fsns_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [fsns_pkg::CFG_AW-1:0]         cfg_index,
  input  logic [fsns_pkg::CFG_DW-1:0]         cfg_data
);

  fsns_pkg::in_item_t  in_item_r;
  logic                in_valid_r;
  fsns_pkg::out_item_t out_item_r;
  logic                out_valid_r;
  fsns_pkg::cfg_t      cfg_r;

  logic                advance;
  logic                in_take;
  logic                emit;
  fsns_pkg::out_item_t result;

  // The held item moves on when the result register is free or being drained.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  fsns_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .emit    (emit),
    .result  (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item_r <= result;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radix_mode      <= fsns_pkg::RADIX_RST;
      cfg_r.dst_bits        <= fsns_pkg::DST_BITS_RST;
      cfg_r.four_state_dest <= fsns_pkg::FOUR_STATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fsns_pkg::REG_RADIX:      cfg_r.radix_mode      <= cfg_data[1:0];
        fsns_pkg::REG_DST_BITS:   cfg_r.dst_bits        <= cfg_data;
        fsns_pkg::REG_FOUR_STATE: cfg_r.four_state_dest <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fsns_checker.sv =====
module fsns_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fsns_pkg::out_item_t out_item
);

  // A result waiting on a stall stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // A mismatch carries empty planes.
  a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.match_ok |->
      out_item.value_plane == '0 && out_item.unknown_plane == '0)
    else $error("mismatch with nonzero planes");

  // A returned sign only comes with a mismatch.
  a_sign_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.sign_returned |-> !out_item.match_ok)
    else $error("sign returned on a match");

  // A taken ending character is a lone x or z, never the end of input.
  a_ender: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.ender_consumed |-> out_item.match_ok && !out_item.hit_end)
    else $error("bad ender flag");

  // Reset empties both channels.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels busy after reset");

endmodule

bind four_state_numeric_field_scanner fsns_checker u_fsns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASES        = 16;
  localparam int unsigned PHASE_ITEMS   = 78;
  localparam int unsigned REPORT_MAX    = 10;

  // Clock, reset and the block's ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  fsns_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  fsns_pkg::out_item_t           out_item;
  logic                          cfg_we = 1'b0;
  logic [fsns_pkg::CFG_AW-1:0]   cfg_index = '0;
  logic [fsns_pkg::CFG_DW-1:0]   cfg_data = '0;

  four_state_numeric_field_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scanner state as the bench sees it, plus its copy of the registers.
  logic [1:0]                  cur_radix = fsns_pkg::RADIX_RST;
  logic [fsns_pkg::CFG_DW-1:0] cur_width = fsns_pkg::DST_BITS_RST;
  logic                        cur_four  = fsns_pkg::FOUR_STATE_RST;

  logic [1:0]  fld_phase = fsns_pkg::PH_SKIP;
  logic        fld_neg   = 1'b0;
  logic        fld_digit = 1'b0;
  logic [63:0] fld_val   = '0;
  logic [63:0] fld_unk   = '0;

  fsns_pkg::out_item_t field_results_due[$];
  fsns_pkg::out_item_t oldest_due;
  int unsigned n_bad = 0;
  int unsigned random_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  // Directed stimulus table: register settings and characters, some with
  // their result typed in.
  typedef struct {
    bit                          setting;
    logic [1:0]                  radix;
    logic [fsns_pkg::CFG_DW-1:0] width;
    logic                        four;
    fsns_pkg::in_item_t          item;
    bit                          typed;
    bit                          typed_has;
    fsns_pkg::out_item_t         typed_res;
  } drill_row_t;

  drill_row_t drill_rows[$];

  // Builds a result item; width truncation is left to whoever types it in.
  function automatic fsns_pkg::out_item_t field_result(logic [63:0] v, logic [63:0] u,
                                                       logic ok, logic ender, logic sgn,
                                                       logic at_end);
    fsns_pkg::out_item_t r;
    r.value_plane    = v;
    r.unknown_plane  = u;
    r.match_ok       = ok;
    r.ender_consumed = ender;
    r.sign_returned  = sgn;
    r.hit_end        = at_end;
    return r;
  endfunction

  function automatic void row_cfg(logic [1:0] r, logic [fsns_pkg::CFG_DW-1:0] w, logic f);
    drill_row_t row;
    row = '{default: '0};
    row.setting = 1'b1;
    row.radix   = r;
    row.width   = w;
    row.four    = f;
    drill_rows.insert(drill_rows.size(), row);
  endfunction

  function automatic void row_char(logic [7:0] c, logic e, bit typed, bit has,
                                   fsns_pkg::out_item_t res);
    drill_row_t row;
    row = '{default: '0};
    row.item.char_code    = c;
    row.item.end_of_input = e;
    row.typed             = typed;
    row.typed_has         = has;
    row.typed_res         = res;
    drill_rows.insert(drill_rows.size(), row);
  endfunction

  // Sorts a character into digit, x, z, separator or none for a radix.
  function automatic logic [2:0] char_kind(logic [7:0] ch, logic [1:0] radix,
                                           output logic [3:0] dig);
    dig = ch[3:0];
    if (ch == "_") return fsns_pkg::KIND_SEP;
    if (radix == fsns_pkg::RADIX_DEC)
      return (ch >= "0" && ch <= "9") ? fsns_pkg::KIND_DIGIT : fsns_pkg::KIND_NONE;
    if (ch == "x" || ch == "X") return fsns_pkg::KIND_X;
    if (ch == "z" || ch == "Z" || ch == "?") return fsns_pkg::KIND_Z;
    if (radix == fsns_pkg::RADIX_HEX) begin
      if (ch >= "0" && ch <= "9") return fsns_pkg::KIND_DIGIT;
      // Letters a-f and A-F carry their value minus nine in the low nibble.
      if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
        dig = ch[3:0] + 4'd9;
        return fsns_pkg::KIND_DIGIT;
      end
      return fsns_pkg::KIND_NONE;
    end
    if (radix == fsns_pkg::RADIX_OCT)
      return (ch >= "0" && ch <= "7") ? fsns_pkg::KIND_DIGIT : fsns_pkg::KIND_NONE;
    return (ch == "0" || ch == "1") ? fsns_pkg::KIND_DIGIT : fsns_pkg::KIND_NONE;
  endfunction

  // Applies width and two-state rules, then returns the field state to idle.
  function automatic fsns_pkg::out_item_t close_field(logic ok, logic [63:0] v,
                                                      logic [63:0] u, logic ender,
                                                      logic sgn, logic at_end);
    logic [63:0] mask;
    int unsigned w;
    w = (cur_width > fsns_pkg::MAX_WIDTH) ? fsns_pkg::MAX_WIDTH : cur_width;
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    if (!ok) begin
      v = '0;
      u = '0;
    end
    if (!cur_four) begin
      v = v & ~u;
      u = '0;
    end
    fld_phase = fsns_pkg::PH_SKIP;
    fld_neg   = 1'b0;
    fld_digit = 1'b0;
    fld_val   = '0;
    fld_unk   = '0;
    return field_result(v & mask, u & mask, ok, ender, sgn, at_end);
  endfunction

  function automatic fsns_pkg::out_item_t finish_number(logic at_end);
    if (!fld_digit) return close_field(1'b0, '0, '0, 1'b0, 1'b0, at_end);
    if (cur_radix == fsns_pkg::RADIX_DEC)
      return close_field(1'b1, fld_neg ? (64'd0 - fld_val) : fld_val, '0, 1'b0, 1'b0,
                         at_end);
    return close_field(1'b1, fld_val, fld_unk, 1'b0, 1'b0, at_end);
  endfunction

  // Shifts one digit, x or z into the value and unknown planes.
  function automatic void shift_digit(logic [2:0] kind, logic [3:0] dig);
    int unsigned k;
    logic [63:0] ones;
    if (kind == fsns_pkg::KIND_SEP) return;
    if (cur_radix == fsns_pkg::RADIX_DEC) begin
      fld_val   = fld_val * 64'd10 + {60'd0, dig};
      fld_digit = 1'b1;
      return;
    end
    k = (cur_radix == fsns_pkg::RADIX_HEX) ? 4 : ((cur_radix == fsns_pkg::RADIX_OCT) ? 3 : 1);
    ones = (64'd1 << k) - 64'd1;
    fld_val = fld_val << k;
    fld_unk = fld_unk << k;
    if (kind == fsns_pkg::KIND_X) begin
      fld_val = fld_val | ones;
      fld_unk = fld_unk | ones;
    end else if (kind == fsns_pkg::KIND_Z) begin
      fld_unk = fld_unk | ones;
    end else begin
      fld_val = fld_val | {60'd0, dig};
    end
    fld_digit = 1'b1;
  endfunction

  // Advances the scan by one character and gives the result it causes, if any.
  function automatic void scan_char(fsns_pkg::in_item_t it, output bit has,
                                    output fsns_pkg::out_item_t res);
    logic [7:0] ch;
    logic       eoi;
    logic [2:0] kind;
    logic [3:0] dig;
    ch  = it.char_code;
    eoi = it.end_of_input;
    has = 1'b0;
    res = '0;
    if (fld_phase == fsns_pkg::PH_SIGN) begin
      // After a sign only a decimal digit keeps the field alive.
      if (!eoi && ch >= "0" && ch <= "9") begin
        fld_val   = {60'd0, ch[3:0]};
        fld_digit = 1'b1;
        fld_phase = fsns_pkg::PH_DIGITS;
      end else begin
        has = 1'b1;
        res = close_field(1'b0, '0, '0, 1'b0, 1'b1, eoi);
      end
    end else if (fld_phase == fsns_pkg::PH_DIGITS) begin
      if (eoi) begin
        has = 1'b1;
        res = finish_number(1'b1);
      end else begin
        kind = char_kind(ch, cur_radix, dig);
        if (kind == fsns_pkg::KIND_NONE) begin
          has = 1'b1;
          res = finish_number(1'b0);
        end else begin
          shift_digit(kind, dig);
        end
      end
    end else begin
      // Whitespace skipping; the spare phase code lands here as well.
      fld_phase = fsns_pkg::PH_SKIP;
      if (eoi) begin
        has = 1'b1;
        res = close_field(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
      end else if (ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13)) begin
        has = 1'b0;
      end else if (cur_radix == fsns_pkg::RADIX_DEC) begin
        if (ch == "x" || ch == "X") begin
          has = 1'b1;
          res = close_field(1'b1, '1, '1, 1'b1, 1'b0, 1'b0);
        end else if (ch == "z" || ch == "Z" || ch == "?") begin
          has = 1'b1;
          res = close_field(1'b1, '0, '1, 1'b1, 1'b0, 1'b0);
        end else if (ch == "+" || ch == "-") begin
          fld_neg   = (ch == "-");
          fld_phase = fsns_pkg::PH_SIGN;
        end else if (ch >= "0" && ch <= "9") begin
          fld_val   = {60'd0, ch[3:0]};
          fld_digit = 1'b1;
          fld_phase = fsns_pkg::PH_DIGITS;
        end else begin
          has = 1'b1;
          res = close_field(1'b0, '0, '0, 1'b0, 1'b0, 1'b0);
        end
      end else begin
        kind = char_kind(ch, cur_radix, dig);
        if (kind == fsns_pkg::KIND_NONE) begin
          has = 1'b1;
          res = close_field(1'b0, '0, '0, 1'b0, 1'b0, 1'b0);
        end else begin
          shift_digit(kind, dig);
          fld_phase = fsns_pkg::PH_DIGITS;
        end
      end
    end
  endfunction

  // Offers one item, waits for it to be taken, then records what it should cause.
  task automatic send_char(logic [7:0] c, logic e, bit typed, bit typed_has,
                           fsns_pkg::out_item_t typed_res);
    fsns_pkg::in_item_t  it;
    bit                  has;
    fsns_pkg::out_item_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.char_code    = c;
    it.end_of_input = e;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_char(it, has, res);
    if (typed) begin
      if (typed_has) field_results_due.insert(field_results_due.size(), typed_res);
    end else if (has) begin
      field_results_due.insert(field_results_due.size(), res);
    end
  endtask

  task automatic send_plain(logic [7:0] c, logic e);
    random_items++;
    send_char(c, e, 1'b0, 1'b0, '0);
  endtask

  // Writes all three registers once the scanner has gone quiet.
  task automatic apply_setting(logic [1:0] r, logic [fsns_pkg::CFG_DW-1:0] w, logic f);
    in_valid <= 1'b0;
    while (field_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= fsns_pkg::REG_RADIX;
    cfg_data  <= {5'd0, r};
    @(posedge clk);
    cur_radix = r;
    cfg_index <= fsns_pkg::REG_DST_BITS;
    cfg_data  <= w;
    @(posedge clk);
    cur_width = w;
    cfg_index <= fsns_pkg::REG_FOUR_STATE;
    cfg_data  <= {6'd0, f};
    @(posedge clk);
    cur_four = f;
    cfg_we <= 1'b0;
  endtask

  // Picks a character that belongs in a field of the current radix.
  function automatic logic [7:0] digit_char(bit first);
    string       odd = "xXzZ?_";
    int unsigned r;
    logic [7:0]  c;
    case (cur_radix)
      fsns_pkg::RADIX_DEC: begin
        r = $urandom_range(9);
        c = 8'("0" + r);
        if (!first && $urandom_range(6) == 0) c = "_";
      end
      fsns_pkg::RADIX_HEX: begin
        r = $urandom_range(27);
        if (r < 10) c = 8'("0" + r);
        else if (r < 16) c = 8'("a" + r - 10);
        else if (r < 22) c = 8'("A" + r - 16);
        else c = odd[r - 22];
      end
      fsns_pkg::RADIX_OCT: begin
        r = $urandom_range(13);
        c = (r < 8) ? 8'("0" + r) : odd[r - 8];
      end
      default: begin
        r = $urandom_range(7);
        c = (r < 2) ? 8'("0" + r) : odd[r - 2];
      end
    endcase
    return c;
  endfunction

  // Mostly well-formed fields with random content; the rest is noise.
  task automatic send_random_field();
    string       lone = "xXzZ?";
    int unsigned pick, n, i, r;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 12) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(255));
        send_plain(c, $urandom_range(19) == 0);
      end
    end else begin
      if ($urandom_range(2) == 0) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          r = $urandom_range(5);
          c = (r == 5) ? 8'd32 : 8'd9 + r[7:0];
          send_plain(c, 1'b0);
        end
      end
      if (cur_radix == fsns_pkg::RADIX_DEC && pick < 20) begin
        send_plain(lone[$urandom_range(4)], 1'b0);
      end else begin
        if (cur_radix == fsns_pkg::RADIX_DEC && pick < 40)
          send_plain((pick < 30) ? "-" : "+", 1'b0);
        // Occasionally empty, occasionally long enough to overflow 64 bits.
        if ($urandom_range(15) == 0) n = 0;
        else if ($urandom_range(7) != 0) n = $urandom_range(1, 6);
        else if (cur_radix == fsns_pkg::RADIX_BIN) n = $urandom_range(60, 70);
        else if (cur_radix == fsns_pkg::RADIX_DEC) n = $urandom_range(18, 24);
        else n = $urandom_range(14, 24);
        for (i = 0; i < n; i++) send_plain(digit_char(i == 0), 1'b0);
        c = 8'($urandom_range(255));
        send_plain(c, $urandom_range(3) == 0);
      end
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Each result taken is compared with the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (field_results_due.size() == 0) begin
        n_bad++;
        if (n_bad <= REPORT_MAX)
          $display("unexpected result item: value %h unknown %h ok %b ender %b sign %b end %b",
                   out_item.value_plane, out_item.unknown_plane, out_item.match_ok,
                   out_item.ender_consumed, out_item.sign_returned, out_item.hit_end);
      end else begin
        oldest_due = field_results_due.pop_front();
        if (out_item.value_plane !== oldest_due.value_plane ||
            out_item.unknown_plane !== oldest_due.unknown_plane ||
            out_item.match_ok !== oldest_due.match_ok ||
            out_item.ender_consumed !== oldest_due.ender_consumed ||
            out_item.sign_returned !== oldest_due.sign_returned ||
            out_item.hit_end !== oldest_due.hit_end) begin
          n_bad++;
          if (n_bad <= REPORT_MAX) begin
            $display("result mismatch, expected / actual:");
            $display("  value %h / %h  unknown %h / %h",
                     oldest_due.value_plane, out_item.value_plane,
                     oldest_due.unknown_plane, out_item.unknown_plane);
            $display("  ok %b/%b ender %b/%b sign %b/%b end %b/%b",
                     oldest_due.match_ok, out_item.match_ok,
                     oldest_due.ender_consumed, out_item.ender_consumed,
                     oldest_due.sign_returned, out_item.sign_returned,
                     oldest_due.hit_end, out_item.hit_end);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned                 p, phase_end;
    logic [fsns_pkg::CFG_DW-1:0] w;
    localparam logic [63:0] LOW32 = 64'h0000_0000_FFFF_FFFF;

    // Reset setting: decimal, 32 bits, four-state.
    row_char(8'h00, 1'b1, 1'b1, 1'b1, field_result('0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
    row_char("x", 1'b0, 1'b1, 1'b1, field_result(LOW32, LOW32, 1'b1, 1'b1, 1'b0, 1'b0));
    row_char("?", 1'b0, 1'b1, 1'b1, field_result('0, LOW32, 1'b1, 1'b1, 1'b0, 1'b0));
    row_char(8'd9, 1'b0, 1'b1, 1'b0, '0);
    row_char("-", 1'b0, 1'b1, 1'b0, '0);
    row_char("7", 1'b0, 1'b1, 1'b0, '0);
    row_char("_", 1'b0, 1'b1, 1'b0, '0);
    // Minus seven in 32 bits.
    row_char(";", 1'b0, 1'b1, 1'b1,
             field_result(64'h0000_0000_FFFF_FFF9, '0, 1'b1, 1'b0, 1'b0, 1'b0));
    // A sign with no digit behind it goes back to the source.
    row_char("+", 1'b0, 1'b1, 1'b0, '0);
    row_char("9", 1'b1, 1'b1, 1'b1, field_result('0, '0, 1'b0, 1'b0, 1'b1, 1'b1));
    row_char("_", 1'b0, 1'b1, 1'b1, field_result('0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    row_char(8'hFF, 1'b0, 1'b1, 1'b1, field_result('0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Hex with a width past the maximum, then a field of separators only.
    row_cfg(fsns_pkg::RADIX_HEX, 7'd127, 1'b1);
    row_char("x", 1'b0, 1'b0, 1'b0, '0);
    row_char("Z", 1'b0, 1'b0, 1'b0, '0);
    row_char("f", 1'b0, 1'b0, 1'b0, '0);
    row_char("9", 1'b0, 1'b0, 1'b0, '0);
    row_char(8'h00, 1'b1, 1'b0, 1'b0, '0);
    row_char("_", 1'b0, 1'b0, 1'b0, '0);
    row_char("g", 1'b0, 1'b1, 1'b1, field_result('0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Binary, one bit, two-state destination.
    row_cfg(fsns_pkg::RADIX_BIN, 7'd1, 1'b0);
    row_char("1", 1'b0, 1'b0, 1'b0, '0);
    row_char("x", 1'b0, 1'b0, 1'b0, '0);
    row_char("0", 1'b0, 1'b0, 1'b0, '0);
    row_char("2", 1'b0, 1'b0, 1'b0, '0);
    // Octal with zero width gives empty planes.
    row_cfg(fsns_pkg::RADIX_OCT, 7'd0, 1'b1);
    row_char("7", 1'b0, 1'b0, 1'b0, '0);
    row_char("?", 1'b0, 1'b0, 1'b0, '0);
    row_char(8'h00, 1'b1, 1'b1, 1'b1, field_result('0, '0, 1'b1, 1'b0, 1'b0, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (drill_rows[i]) begin
      if (drill_rows[i].setting)
        apply_setting(drill_rows[i].radix, drill_rows[i].width, drill_rows[i].four);
      else
        send_char(drill_rows[i].item.char_code, drill_rows[i].item.end_of_input,
                  drill_rows[i].typed, drill_rows[i].typed_has, drill_rows[i].typed_res);
    end

    // Random phases: every radix meets every idling mode and both destinations.
    for (p = 0; p < PHASES; p++) begin
      case ((p + p / 4) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      case (p)
        0: w = 7'd64;
        1: w = 7'd1;
        2: w = 7'd127;
        3: w = 7'd0;
        4: w = 7'd63;
        5: w = 7'd65;
        default: w = ($urandom_range(7) == 0) ?
                     fsns_pkg::CFG_DW'($urandom_range(65, 127)) :
                     fsns_pkg::CFG_DW'($urandom_range(1, 64));
      endcase
      apply_setting(p[1:0], w, p[2] ^ p[3]);
      phase_end = random_items + PHASE_ITEMS;
      while (random_items < phase_end) send_random_field();
      // End of input closes whatever field is open.
      send_plain(8'($urandom_range(255)), 1'b1);
    end

    in_valid <= 1'b0;
    while (field_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (n_bad == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
